/* rtl/pointer_cursor_integrator_assert.svh */
// ----------------------------------------------------------------------------
// pointer cursor integrator assertion macros
// short forms for the concurrent checks used in the rtl
// ----------------------------------------------------------------------------
`ifndef POINTER_CURSOR_INTEGRATOR_ASSERT_SVH
`define POINTER_CURSOR_INTEGRATOR_ASSERT_SVH

// same-cycle implication, off during reset
`define PCI_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pointer cursor integrator check failed");

// next-cycle implication, off during reset
`define PCI_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pointer cursor integrator check failed");

`endif

/* rtl/pci_pkg.sv */
// ----------------------------------------------------------------------------
// pci_pkg
// widths, register indices and fixed-point helpers for the cursor integrator
// ----------------------------------------------------------------------------
package pci_pkg;

  localparam int FRAC_BITS = 14;

  localparam int CoordW   = 16;
  localparam int ElapsedW = 10;
  localparam int SpmW     = 15;
  localparam int TimerW   = 16;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  // shared multiplier: 16 bit signed by 26 bit signed
  localparam int MulAW = 16;
  localparam int MulBW = 26;
  localparam int ProdW = MulAW + MulBW;
  localparam int StepW = SpmW + ElapsedW;

  localparam logic [CfgIdxW-1:0] RegRelativeMode  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegAutohideEn    = 3'd1;
  localparam logic [CfgIdxW-1:0] RegStepPerMs     = 3'd2;
  localparam logic [CfgIdxW-1:0] RegHideDeadzone  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegHideTimeMs    = 3'd4;

  localparam logic [SpmW-1:0]   StepPerMsReset    = 15'd16;
  localparam logic [SpmW-1:0]   HideDeadzoneReset = 15'd328;
  localparam logic [TimerW-1:0] HideTimeReset     = 16'd2500;

  localparam logic signed [ProdW-1:0] OneQ    = ProdW'(1) << FRAC_BITS;
  localparam logic signed [ProdW-1:0] NegOneQ = -OneQ;
  localparam logic signed [ProdW-1:0] HalfQ   = ProdW'(1) << (FRAC_BITS - 1);

  // clamp to -1.0 .. +1.0
  function automatic logic signed [CoordW-1:0] sat_one(input logic signed [ProdW-1:0] v);
    logic signed [ProdW-1:0] c;
    c = v;
    if (v > OneQ) c = OneQ;
    else if (v < NegOneQ) c = NegOneQ;
    return c[CoordW-1:0];
  endfunction

  // round product to nearest (ties up), add to position, clamp
  function automatic logic signed [CoordW-1:0] round_add_sat(
    input logic signed [CoordW-1:0] pos,
    input logic signed [ProdW-1:0]  prod
  );
    logic signed [ProdW-1:0] rounded;
    logic signed [ProdW-1:0] total;
    rounded = (prod + HalfQ) >>> FRAC_BITS;
    total   = rounded + ProdW'(pos);
    return sat_one(total);
  endfunction

endpackage

/* rtl/pci_if.sv */
// ----------------------------------------------------------------------------
// pci channel interfaces
// poll request, result and register write channels with valid/ready
// ----------------------------------------------------------------------------
interface pci_in_if import pci_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic signed [CoordW-1:0]   stick_x;
  logic signed [CoordW-1:0]   stick_y;
  logic        [ElapsedW-1:0] elapsed_ms;
  logic                       relative_hold;
  logic                       recenter;
  logic                       hide_button;
  logic                       input_gate;

  modport source (output valid, stick_x, stick_y, elapsed_ms, relative_hold, recenter,
                  hide_button, input_gate, input ready);
  modport sink (input valid, stick_x, stick_y, elapsed_ms, relative_hold, recenter,
                hide_button, input_gate, output ready);
endinterface

interface pci_out_if import pci_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic signed [CoordW-1:0] cursor_x;
  logic signed [CoordW-1:0] cursor_y;
  logic                     visible;

  modport source (output valid, cursor_x, cursor_y, visible, input ready);
  modport sink (input valid, cursor_x, cursor_y, visible, output ready);
endinterface

interface pci_cfg_if import pci_pkg::*;;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* rtl/pointer_cursor_integrator.sv */
// ----------------------------------------------------------------------------
// pointer_cursor_integrator
// turns stick polls into a Q2.14 cursor position with auto-hide
// ----------------------------------------------------------------------------
// A poll is taken only while idle, then runs through SStep, SMulX, SMulY,
// SPosY and SFinish; SFinish loads the output register and returns to idle.
// A single multiplier is used three times per poll (step_per_ms * elapsed_ms,
// then the x and y products), each pass followed by its product register. If
// the previous result has not been taken the block waits with the new result
// until the output register frees. Register writes take effect at once and
// are expected only while idle.
module pointer_cursor_integrator import pci_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  pci_in_if.sink    poll,
  pci_out_if.source result,
  pci_cfg_if.sink   cfg
);

`include "pointer_cursor_integrator_assert.svh"

  localparam logic [2:0] SIdle   = 3'd0;
  localparam logic [2:0] SStep   = 3'd1;
  localparam logic [2:0] SMulX   = 3'd2;
  localparam logic [2:0] SMulY   = 3'd3;
  localparam logic [2:0] SPosY   = 3'd4;
  localparam logic [2:0] SFinish = 3'd5;

  logic [2:0] state;

  // registers
  logic              relative_mode;
  logic              autohide_enable;
  logic [SpmW-1:0]   step_per_ms;
  logic [SpmW-1:0]   hide_deadzone;
  logic [TimerW-1:0] hide_time_ms;

  // latched poll
  logic signed [CoordW-1:0] stick_x;
  logic signed [CoordW-1:0] stick_y;
  logic [ElapsedW-1:0]      elapsed;
  logic                     rel;
  logic                     center;
  logic                     hide_btn;
  logic                     gate;
  logic [StepW-1:0]         step;

  // state
  logic signed [CoordW-1:0] position_x;
  logic signed [CoordW-1:0] position_y;
  logic signed [CoordW-1:0] previous_x;
  logic signed [CoordW-1:0] previous_y;
  logic [TimerW-1:0]        hide_timer;
  logic [TimerW-1:0]        hide_timer_next;

  // output register
  logic                     out_valid;
  logic signed [CoordW-1:0] out_x;
  logic signed [CoordW-1:0] out_y;
  logic                     out_vis;

  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;
  logic signed [ProdW-1:0] prod;

  logic signed [CoordW:0] diff_x;
  logic signed [CoordW:0] diff_y;
  logic [CoordW:0]        abs_x;
  logic [CoordW:0]        abs_y;
  logic                   moved;
  logic                   shown;
  logic                   commit;
  logic                   poll_take;
  logic                   pos_in_range;

  assign poll.ready   = (state == SIdle);
  assign poll_take    = poll.valid && poll.ready;
  assign cfg.ready    = 1'b1;

  assign result.valid    = out_valid;
  assign result.cursor_x = out_x;
  assign result.cursor_y = out_y;
  assign result.visible  = out_vis;

  assign pos_in_range = (ProdW'(position_x) <= OneQ) && (ProdW'(position_x) >= NegOneQ) &&
                        (ProdW'(position_y) <= OneQ) && (ProdW'(position_y) >= NegOneQ);

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      SStep: begin
        mul_a = MulAW'(step_per_ms);
        mul_b = MulBW'(elapsed);
      end
      SMulX: begin
        mul_a = stick_x;
        mul_b = MulBW'(prod[StepW-1:0]);
      end
      SMulY: begin
        mul_a = stick_y;
        mul_b = MulBW'(step);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  pci_mul_unit u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // movement and timer
  always_comb begin
    diff_x = (CoordW+1)'(previous_x) - (CoordW+1)'(position_x);
    diff_y = (CoordW+1)'(previous_y) - (CoordW+1)'(position_y);
    abs_x  = diff_x[CoordW] ? (CoordW+1)'(-diff_x) : (CoordW+1)'(diff_x);
    abs_y  = diff_y[CoordW] ? (CoordW+1)'(-diff_y) : (CoordW+1)'(diff_y);
    moved  = (abs_x > (CoordW+1)'(hide_deadzone)) || (abs_y > (CoordW+1)'(hide_deadzone));
    priority if (!autohide_enable || moved) begin
      hide_timer_next = hide_time_ms;
    end else if (TimerW'(elapsed) < hide_timer) begin
      hide_timer_next = hide_timer - TimerW'(elapsed);
    end else begin
      hide_timer_next = '0;
    end
    shown  = (hide_timer_next != '0) && gate && !hide_btn;
    commit = (state == SFinish) && (!out_valid || result.ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      relative_mode   <= 1'b0;
      autohide_enable <= 1'b0;
      step_per_ms     <= StepPerMsReset;
      hide_deadzone   <= HideDeadzoneReset;
      hide_time_ms    <= HideTimeReset;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        RegRelativeMode: relative_mode   <= cfg.data[0];
        RegAutohideEn:   autohide_enable <= cfg.data[0];
        RegStepPerMs:    step_per_ms     <= cfg.data[SpmW-1:0];
        RegHideDeadzone: hide_deadzone   <= cfg.data[SpmW-1:0];
        RegHideTimeMs:   hide_time_ms    <= cfg.data[TimerW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= SIdle;
      out_valid  <= 1'b0;
      position_x <= '0;
      position_y <= '0;
      previous_x <= '0;
      previous_y <= '0;
      hide_timer <= '0;
    end else begin
      if (commit) out_valid <= 1'b1;
      else if (result.ready) out_valid <= 1'b0;
      unique case (state)
        SIdle: begin
          if (poll_take) state <= SStep;
        end
        SStep: state <= SMulX;
        SMulX: state <= SMulY;
        SMulY: begin
          if (!rel) position_x <= stick_x;
          else if (center) position_x <= '0;
          else position_x <= round_add_sat(position_x, prod);
          state <= SPosY;
        end
        SPosY: begin
          if (!rel) position_y <= stick_y;
          else if (center) position_y <= '0;
          else position_y <= round_add_sat(position_y, prod);
          state <= SFinish;
        end
        SFinish: begin
          if (commit) begin
            previous_x <= position_x;
            previous_y <= position_y;
            hide_timer <= hide_timer_next;
            state      <= SIdle;
          end
        end
        default: state <= SIdle;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (poll_take) begin
      stick_x  <= sat_one(ProdW'(poll.stick_x));
      stick_y  <= sat_one(ProdW'(poll.stick_y));
      elapsed  <= poll.elapsed_ms;
      rel      <= relative_mode ^ poll.relative_hold;
      center   <= poll.recenter;
      hide_btn <= poll.hide_button;
      gate     <= poll.input_gate;
    end
    if (state == SMulX) step <= prod[StepW-1:0];
    if (commit) begin
      out_x   <= shown ? position_x : '0;
      out_y   <= shown ? position_y : '0;
      out_vis <= shown;
    end
  end

  `PCI_ASSERT_SAME(a_busy_not_ready, clk, rst, state != SIdle, !poll.ready)
  `PCI_ASSERT_NEXT(a_take_starts, clk, rst, poll_take, state == SStep)
  `PCI_ASSERT_SAME(a_hidden_zero, clk, rst, out_valid && !out_vis, out_x == '0 && out_y == '0)
  `PCI_ASSERT_SAME(a_pos_range, clk, rst, 1'b1, pos_in_range)
  `PCI_ASSERT_NEXT(a_commit_fills, clk, rst, commit, out_valid && state == SIdle)

endmodule

/* rtl/pci_mul_unit.sv */
// ----------------------------------------------------------------------------
// pci_mul_unit
// shared signed multiplier with registered product
// ----------------------------------------------------------------------------
module pci_mul_unit import pci_pkg::*; (
  input  logic                    clk,
  input  logic signed [MulAW-1:0] a,
  input  logic signed [MulBW-1:0] b,
  output logic signed [ProdW-1:0] prod
);

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule
